// ===== rtl/alpha_weighted_bilinear_sampler_macros.svh =====
// Assertion macros used by the checker file of the sampler.
`ifndef ALPHA_WEIGHTED_BILINEAR_SAMPLER_MACROS_SVH
`define ALPHA_WEIGHTED_BILINEAR_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define AWBS_ASSERT_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("sampler check failed");

// Next-cycle implication, disabled while dis is high.
`define AWBS_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("sampler check failed");

`endif

// ===== rtl/awbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alpha-weighted bilinear sampler package
// Shared payload types, constants and register indexes.
// ----------------------------------------------------------------------------
package awbs_pkg;

    localparam int DEF_MAX_DIM = 4096;
    localparam int NUM_LANES   = 4;
    localparam int DIV_STAGES  = 8;
    localparam int CFG_ADDR_W  = 3;

    // Register indexes (byte address bit 2 selects one).
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [12:0] DIM_RESET = 13'd1;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic [31:0]        pixel_tl;
        logic [31:0]        pixel_tr;
        logic [31:0]        pixel_bl;
        logic [31:0]        pixel_br;
    } awbs_in_t;

    typedef struct packed {
        logic        sample_valid;
        logic [31:0] sample_color;
    } awbs_out_t;

    // What one lane hands to the merging stage.
    typedef struct packed {
        logic [15:0] ca;
        logic [23:0] r;
        logic [23:0] g;
        logic [23:0] b;
    } awbs_lane_out_t;

    // Per-request side information that travels along the pipeline.
    typedef struct packed {
        logic        sample_valid;
        logic        pass;
        logic [31:0] color;
        logic [7:0]  alpha;
        logic        zero;
    } awbs_side_t;

endpackage

// ===== rtl/awbs_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampler lane
// Scales one neighbour's weight by its alpha, then multiplies each color
// channel by the scaled weight. Two register stages.
// ----------------------------------------------------------------------------
module awbs_lane (
    input  logic                     aclk,
    input  logic [1:0]               en,
    input  logic [31:0]              pixel,
    input  logic [7:0]               weight,
    output awbs_pkg::awbs_lane_out_t lane_out
);
    import awbs_pkg::*;

    logic [15:0]    ca_reg;
    logic [23:0]    rgb_reg;
    awbs_lane_out_t out_reg;

    // Alpha times weight; zero alpha gives zero contribution.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ca_reg  <= 16'(pixel[31:24]) * 16'(weight);
            rgb_reg <= pixel[23:0];
        end
    end

    // Channel products with the scaled weight.
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            out_reg.ca <= ca_reg;
            out_reg.r  <= 24'(rgb_reg[23:16]) * 24'(ca_reg);
            out_reg.g  <= 24'(rgb_reg[15:8]) * 24'(ca_reg);
            out_reg.b  <= 24'(rgb_reg[7:0]) * 24'(ca_reg);
        end
    end

    assign lane_out = out_reg;

endmodule

// ===== rtl/awbs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampler divider
// Pipelined restoring divider, one quotient bit per stage. The quotient is
// known to fit in eight bits because the dividend never exceeds 255 times
// the divisor.
// ----------------------------------------------------------------------------
module awbs_div (
    input  logic                                aclk,
    input  logic [awbs_pkg::DIV_STAGES-1:0]     en,
    input  logic [23:0]                         num,
    input  logic [15:0]                         den,
    output logic [awbs_pkg::DIV_STAGES-1:0]     quot
);
    import awbs_pkg::*;

    logic [23:0]           rem_reg [DIV_STAGES];
    logic [15:0]           den_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] q_reg   [DIV_STAGES];

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++) begin : g_stage
            logic [23:0]           rem_in;
            logic [15:0]           den_in;
            logic [DIV_STAGES-1:0] q_in;
            logic [23:0]           den_sh;
            logic                  take;

            if (j == 0) begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign q_in   = '0;
            end else begin : g_rest
                assign rem_in = rem_reg[j-1];
                assign den_in = den_reg[j-1];
                assign q_in   = q_reg[j-1];
            end

            // Try to subtract the divisor at this stage's bit position.
            assign den_sh = 24'(den_in) << (DIV_STAGES - 1 - j);
            assign take   = (rem_in >= den_sh);

            always_ff @(posedge aclk) begin
                if (en[j]) begin
                    rem_reg[j] <= take ? (rem_in - den_sh) : rem_in;
                    den_reg[j] <= den_in;
                    q_reg[j]   <= q_in | (DIV_STAGES'(take) << (DIV_STAGES - 1 - j));
                end
            end
        end
    endgenerate

    assign quot = q_reg[DIV_STAGES-1];

endmodule

// ===== rtl/alpha_weighted_bilinear_sampler.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle while the output is not stalled; the stages are
// decode, two lane stages, the merge and the eight divider stages.
// Stalls collapse bubbles; s_ready is high while any stage is empty or m_ready is high.
// Reset (aresetn low, synchronous) empties the pipeline and sets both image
// dimensions to 1.
// ----------------------------------------------------------------------------
// Alpha-weighted bilinear sampler
// Mixes a 2x2 ARGB neighbourhood with alpha-scaled bilinear weights using
// four parallel lanes, a merging adder stage and pipelined dividers.
// ----------------------------------------------------------------------------
module alpha_weighted_bilinear_sampler #(
    parameter int MAX_DIM = awbs_pkg::DEF_MAX_DIM
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  awbs_pkg::awbs_in_t            s_request,
    output logic                          m_valid,
    input  logic                          m_ready,
    output awbs_pkg::awbs_out_t           m_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [awbs_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import awbs_pkg::*;

    localparam int NSTG      = 4 + DIV_STAGES;
    localparam int STG_MERGE = 3;

    logic [12:0] width_reg, height_reg;
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;
    awbs_side_t side_reg [NSTG];
    logic [31:0] pix_reg [NUM_LANES];
    logic [7:0]  wt_reg  [NUM_LANES];
    awbs_lane_out_t lane_out [NUM_LANES];
    logic [15:0] a_reg;
    logic [23:0] r_sum_reg, g_sum_reg, b_sum_reg;
    logic [7:0]  q_r, q_g, q_b;

    // Configuration registers.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[12:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[12:0];
                default: ;
            endcase
        end
    end
    assign prdata = (paddr[2] == REG_IMAGE_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    // Stage enables: a stage moves when it is empty or its successor moves.
    always_comb begin
        en[NSTG-1] = !v_reg[NSTG-1] || m_ready;
        for (int i = NSTG - 2; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end
    assign s_ready = en[0];
    assign m_valid = v_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Decode: range checks, neighbour masking, equality bypass and weights.
    logic signed [17:0] px, py, px1, py1, dim_w, dim_h;
    logic               out_rng, c0, c1, r0, r1, all_eq;
    logic [31:0]        pm [NUM_LANES];
    logic [7:0]         fx, fy, wa, wb, wc, wd;
    logic [8:0]         nfx, fx1;
    logic [16:0]        p0, p1, p2;
    awbs_side_t         side_dec;

    always_comb begin
        dim_w = (18'(width_reg) > 18'(MAX_DIM)) ? 18'(MAX_DIM) : 18'(width_reg);
        dim_h = (18'(height_reg) > 18'(MAX_DIM)) ? 18'(MAX_DIM) : 18'(height_reg);
        px  = {{2{s_request.coord_x[31]}}, s_request.coord_x[31:16]};
        py  = {{2{s_request.coord_y[31]}}, s_request.coord_y[31:16]};
        px1 = px + 18'sd1;
        py1 = py + 18'sd1;
        out_rng = (px < -18'sd1) || (py < -18'sd1) || (px >= dim_w) || (py >= dim_h);
        c0 = (px >= 18'sd0) && (px < dim_w);
        c1 = (px1 < dim_w);
        r0 = (py >= 18'sd0) && (py < dim_h);
        r1 = (py1 < dim_h);
        pm[0] = (c0 && r0) ? s_request.pixel_tl : 32'd0;
        pm[1] = (c1 && r0) ? s_request.pixel_tr : 32'd0;
        pm[2] = (c0 && r1) ? s_request.pixel_bl : 32'd0;
        pm[3] = (c1 && r1) ? s_request.pixel_br : 32'd0;
        all_eq = (pm[0] == pm[1]) && (pm[0] == pm[2]) && (pm[0] == pm[3]);

        fx  = s_request.coord_x[15:8];
        fy  = s_request.coord_y[15:8];
        nfx = 9'd256 - 9'(fx);
        fx1 = 9'(fx) + 9'd1;
        p0  = 17'(nfx) * 17'(8'd255 - fy);
        p1  = 17'(fx1) * 17'(8'd255 - fy);
        p2  = 17'(nfx) * 17'(fy);
        wa  = p0[15:8];
        wb  = p1[15:8];
        wc  = p2[15:8];
        wd  = 8'(10'd255 - 10'(wa) - 10'(wb) - 10'(wc));

        side_dec.sample_valid = !out_rng;
        side_dec.pass         = out_rng || all_eq;
        side_dec.color        = out_rng ? 32'd0 : pm[0];
        side_dec.alpha        = '0;
        side_dec.zero         = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                pix_reg[i] <= pm[i];
            end
            wt_reg[0] <= wa;
            wt_reg[1] <= wb;
            wt_reg[2] <= wc;
            wt_reg[3] <= wd;
        end
    end

    // Four neighbour lanes.
    genvar k;
    generate
        for (k = 0; k < NUM_LANES; k++) begin : g_lane
            awbs_lane u_lane (
                .aclk     (aclk),
                .en       (en[2:1]),
                .pixel    (pix_reg[k]),
                .weight   (wt_reg[k]),
                .lane_out (lane_out[k])
            );
        end
    endgenerate

    // Merge: sum the lane results and derive the output alpha.
    logic [15:0] a_sum;
    logic [16:0] a_q;
    awbs_side_t  side_merge;
    always_comb begin
        a_sum = lane_out[0].ca + lane_out[1].ca + lane_out[2].ca + lane_out[3].ca;
        a_q   = (17'(a_sum) + 17'd1 + 17'(a_sum[15:8])) >> 8;
        side_merge       = side_reg[STG_MERGE-1];
        side_merge.alpha = a_q[7:0];
        side_merge.zero  = (a_sum == 16'd0);
    end

    always_ff @(posedge aclk) begin
        if (en[STG_MERGE]) begin
            a_reg     <= a_sum;
            r_sum_reg <= lane_out[0].r + lane_out[1].r + lane_out[2].r + lane_out[3].r;
            g_sum_reg <= lane_out[0].g + lane_out[1].g + lane_out[2].g + lane_out[3].g;
            b_sum_reg <= lane_out[0].b + lane_out[1].b + lane_out[2].b + lane_out[3].b;
        end
    end

    // Side information follows its request down the pipeline.
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            side_reg[0] <= side_dec;
        end
        for (int i = 1; i < NSTG; i++) begin
            if (en[i]) begin
                side_reg[i] <= (i == STG_MERGE) ? side_merge : side_reg[i-1];
            end
        end
    end

    // Channel dividers.
    awbs_div u_div_r (.aclk(aclk), .en(en[NSTG-1:4]), .num(r_sum_reg), .den(a_reg), .quot(q_r));
    awbs_div u_div_g (.aclk(aclk), .en(en[NSTG-1:4]), .num(g_sum_reg), .den(a_reg), .quot(q_g));
    awbs_div u_div_b (.aclk(aclk), .en(en[NSTG-1:4]), .num(b_sum_reg), .den(a_reg), .quot(q_b));

    // Result selection.
    always_comb begin
        m_result.sample_valid = side_reg[NSTG-1].sample_valid;
        if (side_reg[NSTG-1].pass) begin
            m_result.sample_color = side_reg[NSTG-1].color;
        end else if (side_reg[NSTG-1].zero) begin
            m_result.sample_color = 32'd0;
        end else begin
            m_result.sample_color = {side_reg[NSTG-1].alpha, q_r, q_g, q_b};
        end
    end

endmodule

// ===== rtl/awbs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sampler port checker
// Watches the result channel and the configuration port over time.
// ----------------------------------------------------------------------------
`include "alpha_weighted_bilinear_sampler_macros.svh"

module awbs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input awbs_pkg::awbs_out_t m_result,
    input logic                pready
);
    import awbs_pkg::*;

    // A stalled result holds.
    `AWBS_ASSERT_NEXT(a_hold, aclk, !aresetn, m_valid && !m_ready, m_valid && $stable(m_result))
    // An out-of-range sample carries a zero color.
    `AWBS_ASSERT_NOW(a_inv_zero, aclk, !aresetn, m_valid && !m_result.sample_valid, m_result.sample_color == 32'd0)
    // Reset empties the pipeline.
    `AWBS_ASSERT_NEXT(a_rst_empty, aclk, 1'b0, !aresetn, !m_valid)
    // The configuration port never waits.
    `AWBS_ASSERT_NOW(a_pready, aclk, 1'b0, 1'b1, pready)

endmodule

bind alpha_weighted_bilinear_sampler awbs_checker u_awbs_checker (.*);
